// ----- hdl/assert_macros.svh -----
// assertion macros included by the scanner top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) not (cond)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- hdl/mpds_pkg.sv -----
// shared types, codes and widths of the dfa scanner
package mpds_pkg;

    localparam int OP_W      = 2;
    localparam int STATE_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int MASK_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int STATE_SPAN = 1 << STATE_W;

    localparam int DEF_NUM_STATES   = 1024;
    localparam int DEF_ALPHABET     = 256;
    localparam int DEF_NUM_PATTERNS = 32;

    localparam logic [OP_W-1:0] OP_WR_TRANS = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_MASK  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART  = 2'd2;
    localparam logic [OP_W-1:0] OP_SCAN     = 2'd3;

    // table memory enables
    typedef struct packed {
        logic tr_we;
        logic tr_re;
        logic mk_we;
        logic mk_re;
    } t_tbl_ctl;

    // statistics counter controls
    typedef struct packed {
        logic clr;
        logic inc_bytes;
        logic load_mask;
        logic accum;
    } t_stat_ctl;

endpackage

// ----- hdl/mpds_tables.sv -----
// transition table and per-state match mask memories
module mpds_tables
    import mpds_pkg::*;
#(
    parameter int N_STATES = DEF_NUM_STATES,
    parameter int ALPHABET = DEF_ALPHABET,
    parameter int PAT_W    = DEF_NUM_PATTERNS,
    localparam int ST_W     = $clog2(N_STATES),
    localparam int AB_W     = $clog2(ALPHABET),
    localparam int TR_AW    = ST_W + AB_W,
    localparam int TR_DEPTH = N_STATES << AB_W
) (
    input  logic             i_clk,
    input  t_tbl_ctl         i_ctl,
    input  logic [TR_AW-1:0] i_tr_addr,
    input  logic [ST_W-1:0]  i_tr_wdata,
    output logic [ST_W-1:0]  o_tr_rdata,
    input  logic [ST_W-1:0]  i_mk_addr,
    input  logic [PAT_W-1:0] i_mk_wdata,
    output logic [PAT_W-1:0] o_mk_rdata
);

    logic [ST_W-1:0]  r_tr_mem [0:TR_DEPTH-1];
    logic [PAT_W-1:0] r_mk_mem [0:N_STATES-1];
    logic [ST_W-1:0]  r_tr_rdata;
    logic [PAT_W-1:0] r_mk_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tr_we) begin
            r_tr_mem[i_tr_addr] <= i_tr_wdata;
        end
        if (i_ctl.tr_re) begin
            r_tr_rdata <= r_tr_mem[i_tr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mk_we) begin
            r_mk_mem[i_mk_addr] <= i_mk_wdata;
        end
        if (i_ctl.mk_re) begin
            r_mk_rdata <= r_mk_mem[i_mk_addr];
        end
    end

    assign o_tr_rdata = r_tr_rdata;
    assign o_mk_rdata = r_mk_rdata;

endmodule

// ----- hdl/mpds_stats.sv -----
// byte and match counters with a two-stage population count
module mpds_stats
    import mpds_pkg::*;
#(
    parameter int PAT_W = DEF_NUM_PATTERNS,
    localparam int GRP_N = (PAT_W + 7) / 8,
    localparam int SUM_W = $clog2(PAT_W + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stat_ctl          i_ctl,
    input  logic [PAT_W-1:0]   i_mask,
    output logic [COUNT_W-1:0] o_bytes,
    output logic [COUNT_W-1:0] o_matches
);

    logic [GRP_N*8-1:0]  mask_pad;
    logic [3:0]          r_grp [GRP_N];
    logic [3:0]          n_grp [GRP_N];
    logic [SUM_W-1:0]    grp_sum;
    logic [COUNT_W-1:0]  r_bytes;
    logic [COUNT_W-1:0]  r_matches;

    assign mask_pad = (GRP_N*8)'(i_mask);

    // first stage: bits set in each byte of the mask
    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                n_grp[g] = n_grp[g] + 4'(mask_pad[g*8+b]);
            end
        end
    end

    // second stage: add the byte counts
    always_comb begin
        grp_sum = '0;
        for (int g = 0; g < GRP_N; g++) begin
            grp_sum = grp_sum + SUM_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mask) begin
            r_grp <= n_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_bytes   <= '0;
            r_matches <= '0;
        end else begin
            if (i_ctl.inc_bytes) begin
                r_bytes <= r_bytes + COUNT_W'(1);
            end
            if (i_ctl.accum) begin
                r_matches <= r_matches + COUNT_W'(grp_sum);
            end
        end
    end

    assign o_bytes   = r_bytes;
    assign o_matches = r_matches;

endmodule

// ----- hdl/multi_pattern_dfa_scanner_top.sv -----
// aho-corasick dfa scanner: command sequencer over table memories
//
// one command channel: an item is taken when start is high and busy is low.
// op selects a transition write, a match mask write, a scan restart or the
// scan of one byte. every item gives exactly one result beat, shown for one
// cycle with o_valid high; the receiver has no way to hold it off.
// a write or a restart: result in the cycle after acceptance; the next item
// is taken only after the result beat.
// a scan byte: the transition memory is read at {state, byte}, then the mask
// memory at the new state, then the mask is counted in two register stages;
// the next byte is taken only after the result beat. an out-of-alphabet byte
// skips the transition read and returns to the root state.
// busy stays high through the result beat, so reads and writes of the tables
// never overlap.
// reset (synchronous, active low) returns the scan to the root state and
// clears both counters; table contents are not cleared and must be loaded
// before they are scanned.
`include "assert_macros.svh"
module multi_pattern_dfa_scanner_top
    import mpds_pkg::*;
#(
    parameter int NUM_STATES   = DEF_NUM_STATES,
    parameter int ALPHABET     = DEF_ALPHABET,
    parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    i_op,
    input  logic [STATE_W-1:0] i_state_index,
    input  logic [BYTE_W-1:0]  i_byte_value,
    input  logic [STATE_W-1:0] i_next_state_value,
    input  logic [MASK_W-1:0]  i_pattern_mask,
    output logic               o_valid,
    output logic [STATE_W-1:0] o_state_after,
    output logic               o_matched,
    output logic [MASK_W-1:0]  o_match_bits,
    output logic [COUNT_W-1:0] o_bytes_seen,
    output logic [COUNT_W-1:0] o_matches_seen
);

    localparam int EFF_STATES = (NUM_STATES < STATE_SPAN) ? NUM_STATES : STATE_SPAN;
    localparam int PAT_W      = (NUM_PATTERNS < MASK_W) ? NUM_PATTERNS : MASK_W;
    localparam int ST_W       = $clog2(EFF_STATES);
    localparam int AB_W       = $clog2(ALPHABET);
    localparam int TR_AW      = ST_W + AB_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRD  = 3'd1;
    localparam logic [2:0] S_MRD  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_fsm;
    logic [2:0]       n_fsm;
    logic [ST_W-1:0]  r_state;
    logic [ST_W-1:0]  n_state;
    logic             r_scan;
    logic [PAT_W-1:0] r_bits;

    logic             accept;
    logic             st_ok;
    logic             by_ok;
    logic             nx_ok;
    t_tbl_ctl         tbl_ctl;
    t_stat_ctl        stat_ctl;
    logic [TR_AW-1:0] tr_addr;
    logic [ST_W-1:0]  tr_rdata;
    logic [ST_W-1:0]  mk_addr;
    logic [PAT_W-1:0] mk_rdata;
    logic [COUNT_W-1:0] bytes_cnt;
    logic [COUNT_W-1:0] match_cnt;

    assign busy   = (r_fsm != S_IDLE);
    assign accept = start && !busy;

    assign st_ok = 32'(i_state_index) < NUM_STATES;
    assign by_ok = 32'(i_byte_value) < ALPHABET;
    assign nx_ok = 32'(i_next_state_value) < NUM_STATES;

    // table addressing: writes use the command fields, a scan uses the live state
    always_comb begin
        tr_addr = {r_state, i_byte_value[AB_W-1:0]};
        if (i_op != OP_SCAN) begin
            tr_addr = {i_state_index[ST_W-1:0], i_byte_value[AB_W-1:0]};
        end
        mk_addr = i_state_index[ST_W-1:0];
        if (r_fsm == S_TRD) begin
            mk_addr = tr_rdata;
        end else if (i_op == OP_SCAN) begin
            mk_addr = '0;
        end
    end

    always_comb begin
        tbl_ctl  = '0;
        stat_ctl = '0;
        n_fsm    = r_fsm;
        n_state  = r_state;
        unique case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    n_fsm = S_DONE;
                    unique case (i_op)
                        OP_WR_TRANS: begin
                            tbl_ctl.tr_we = st_ok && by_ok && nx_ok;
                        end
                        OP_WR_MASK: begin
                            tbl_ctl.mk_we = st_ok;
                        end
                        OP_RESTART: begin
                            stat_ctl.clr = 1'b1;
                            n_state      = '0;
                        end
                        OP_SCAN: begin
                            stat_ctl.inc_bytes = 1'b1;
                            if (by_ok) begin
                                tbl_ctl.tr_re = 1'b1;
                                n_fsm         = S_TRD;
                            end else begin
                                // out of alphabet: back to the root
                                tbl_ctl.mk_re = 1'b1;
                                n_state       = '0;
                                n_fsm         = S_MRD;
                            end
                        end
                        default: begin
                            n_fsm = S_DONE;
                        end
                    endcase
                end
            end
            S_TRD: begin
                tbl_ctl.mk_re = 1'b1;
                n_state       = tr_rdata;
                n_fsm         = S_MRD;
            end
            S_MRD: begin
                stat_ctl.load_mask = 1'b1;
                n_fsm              = S_ACC;
            end
            S_ACC: begin
                stat_ctl.accum = 1'b1;
                n_fsm          = S_DONE;
            end
            S_DONE: begin
                n_fsm = S_IDLE;
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_state <= '0;
            r_scan  <= 1'b0;
        end else begin
            r_fsm   <= n_fsm;
            r_state <= n_state;
            if (accept) begin
                r_scan <= (i_op == OP_SCAN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_MRD) begin
            r_bits <= mk_rdata;
        end
    end

    mpds_tables #(
        .N_STATES (EFF_STATES),
        .ALPHABET (ALPHABET),
        .PAT_W    (PAT_W)
    ) u_tables (
        .i_clk      (i_clk),
        .i_ctl      (tbl_ctl),
        .i_tr_addr  (tr_addr),
        .i_tr_wdata (i_next_state_value[ST_W-1:0]),
        .o_tr_rdata (tr_rdata),
        .i_mk_addr  (mk_addr),
        .i_mk_wdata (i_pattern_mask[PAT_W-1:0]),
        .o_mk_rdata (mk_rdata)
    );

    mpds_stats #(
        .PAT_W (PAT_W)
    ) u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (stat_ctl),
        .i_mask    (mk_rdata),
        .o_bytes   (bytes_cnt),
        .o_matches (match_cnt)
    );

    assign o_valid        = (r_fsm == S_DONE);
    assign o_state_after  = STATE_W'(r_state);
    assign o_match_bits   = r_scan ? MASK_W'(r_bits) : '0;
    assign o_matched      = r_scan && (r_bits != '0);
    assign o_bytes_seen   = bytes_cnt;
    assign o_matches_seen = match_cnt;

    `ASSERT_AT(a_beat_single, i_clk, i_rst_n, o_valid |=> !o_valid, "result beat longer than one cycle")
    `ASSERT_AT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "busy not raised after accept")
    `ASSERT_NEVER(a_beat_idle, i_clk, i_rst_n, o_valid && !busy, "result beat while idle")
    `ASSERT_AT(a_restart_zero, i_clk, i_rst_n, (start && !busy && i_op == OP_RESTART) |=> (o_valid && o_bytes_seen == '0 && o_matches_seen == '0 && o_state_after == '0), "restart result not zero")

endmodule
